### sv/hms_pkg.sv
`timescale 1ns / 1ps
package hms_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned ThrW  = 10;
  localparam int unsigned IdxW  = 10;
  localparam logic [ThrW-1:0] ThrReset = 10'd10;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_READ = 1'b1
  } func_e;

  typedef struct packed {
    logic             func;
    logic [DataW-1:0] load_value;
    logic             is_last;
    logic [IdxW-1:0]  read_index;
  } in_beat_t;

  typedef struct packed {
    logic [DataW-1:0] sorted_value;
    logic             error_flag;
  } out_beat_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_RD_DONE,
    ST_FRAME,
    ST_INS_INIT,
    ST_INS_KEY_RD,
    ST_INS_KEY_WT,
    ST_INS_BS_RD,
    ST_INS_BS_WT,
    ST_INS_SH_RD,
    ST_INS_SH_WT,
    ST_INS_PUT,
    ST_MRG_RD,
    ST_MRG_WT,
    ST_MRG_CMP,
    ST_CPY_RD,
    ST_CPY_WT,
    ST_RET,
    ST_OUT
  } state_e;

  function automatic logic less_s(input logic [DataW-1:0] a, input logic [DataW-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

### sv/hms_if.sv
`timescale 1ns / 1ps
interface hms_in_if
  import hms_pkg::*;
();
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hms_out_if
  import hms_pkg::*;
();
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/hms_ram.sv
`timescale 1ns / 1ps
module hms_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### sv/hybrid_merge_insertion_sort.sv
`timescale 1ns / 1ps
// Hybrid merge / binary-insertion sorter.
// Channels: in_if (sink) carries func, load_value, is_last, read_index;
// out_if (source) carries sorted_value and error_flag. A beat moves when
// valid and ready are both high. cfg_we_i/cfg_wdata_i write split_threshold.
// Loads give no result unless the store is full, in which case one error
// beat is returned. A load with is_last starts a sort; in_if.ready stays
// low until it ends. Insertion runs sort within the store; merges write
// to u_mbuf and are copied back. Each store has one read port. A read
// passes through ST_RD_WAIT and ST_RD_DONE before its beat is registered.
// Reset clears the count, overflow flag and closed flag; the threshold
// returns to 10. Store contents are not cleared. A stalled receiver holds
// the result in the output register and the block accepts nothing further
// until it is taken.
module hybrid_merge_insertion_sort
  import hms_pkg::*;
#(
  parameter int unsigned MaxElements = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [ThrW-1:0] cfg_wdata_i,
  hms_in_if.sink          in_if,
  hms_out_if.source       out_if
);
  localparam int unsigned AW = $clog2(MaxElements);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned SD = 2 * AW + 2;

  state_e state_q, state_d;
  logic [ThrW-1:0] thr_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic ovf_q, ovf_d, closed_q, closed_d;
  out_beat_t obuf_q, obuf_d;
  logic ovalid_q, ovalid_d;
  logic [IdxW-1:0] ridx_q, ridx_d;

  // Explicit range stack: lo, hi, phase (0 = descend, 1 = left done, 2 = merge).
  logic [AW-1:0] stk_lo_q [SD];
  logic [AW-1:0] stk_hi_q [SD];
  logic [1:0]    stk_ph_q [SD];
  logic [$clog2(SD+1)-1:0] sp_q, sp_d;
  logic          push, setph;
  logic [AW-1:0] push_lo, push_hi;
  logic [1:0]    push_ph, new_ph;

  logic [AW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [AW:0]   i_q, i_d, a_q, a_d, b_q, b_d, j_q, j_d, k_q, k_d;
  logic [AW:0]   x_q, x_d, y_q, y_d;
  logic [DataW-1:0] key_q, key_d, vx_q, vx_d;

  logic st_we, mb_we;
  logic [AW-1:0] st_wa, st_ra, mb_wa, mb_ra;
  logic [DataW-1:0] st_wd, mb_wd, st_rd, mb_rd;

  hms_ram #(.Width(DataW), .Depth(MaxElements)) u_store (
    .clk_i, .we_i(st_we), .waddr_i(st_wa), .wdata_i(st_wd),
    .raddr_i(st_ra), .rdata_o(st_rd)
  );
  hms_ram #(.Width(DataW), .Depth(MaxElements)) u_mbuf (
    .clk_i, .we_i(mb_we), .waddr_i(mb_wa), .wdata_i(mb_wd),
    .raddr_i(mb_ra), .rdata_o(mb_rd)
  );

  logic [AW-1:0] top_lo, top_hi;
  logic [1:0]    top_ph;
  logic [AW:0]   span, mpos;
  assign top_lo = stk_lo_q[sp_q[$clog2(SD+1)-1:0] - 1'b1];
  assign top_hi = stk_hi_q[sp_q - 1'b1];
  assign top_ph = stk_ph_q[sp_q - 1'b1];
  assign span   = {1'b0, top_hi} - {1'b0, top_lo};
  assign mpos   = a_q + ((b_q - a_q) >> 1);

  assign in_if.ready = (state_q == ST_IDLE) && !ovalid_q;
  assign out_if.valid = ovalid_q;
  assign out_if.data  = obuf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      thr_q    <= ThrReset;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      closed_q <= 1'b0;
      ovalid_q <= 1'b0;
      sp_q     <= '0;
    end else begin
      state_q  <= state_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
      closed_q <= closed_d;
      ovalid_q <= ovalid_d;
      sp_q     <= sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obuf_q <= obuf_d;
    ridx_q <= ridx_d;
    lo_q <= lo_d; hi_q <= hi_d; mid_q <= mid_d;
    i_q <= i_d; a_q <= a_d; b_q <= b_d; j_q <= j_d; k_q <= k_d;
    x_q <= x_d; y_q <= y_d; key_q <= key_d; vx_q <= vx_d;
    if (push) begin
      stk_lo_q[sp_q] <= push_lo;
      stk_hi_q[sp_q] <= push_hi;
      stk_ph_q[sp_q] <= push_ph;
    end
    if (setph) begin
      stk_ph_q[sp_q - 1'b1] <= new_ph;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q; ovf_d = ovf_q; closed_d = closed_q;
    obuf_d = obuf_q; ovalid_d = ovalid_q; ridx_d = ridx_q;
    sp_d = sp_q; push = 1'b0; setph = 1'b0;
    push_lo = '0; push_hi = '0; push_ph = 2'd0; new_ph = 2'd0;
    lo_d = lo_q; hi_d = hi_q; mid_d = mid_q;
    i_d = i_q; a_d = a_q; b_d = b_q; j_d = j_q; k_d = k_q;
    x_d = x_q; y_d = y_q; key_d = key_q; vx_d = vx_q;
    st_we = 1'b0; st_wa = '0; st_wd = '0; st_ra = '0;
    mb_we = 1'b0; mb_wa = '0; mb_wd = '0; mb_ra = '0;

    if (out_if.valid && out_if.ready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_if.valid && in_if.ready) begin
          if (in_if.data.func == FUNC_READ) begin
            ridx_d = in_if.data.read_index;
            st_ra  = AW'(in_if.data.read_index);
            state_d = ST_RD_WAIT;
          end else begin
            logic [CW-1:0] c;
            c = closed_q ? '0 : cnt_q;
            if (closed_q) begin
              ovf_d = 1'b0;
              closed_d = 1'b0;
            end
            if (c < CW'(MaxElements)) begin
              st_we = 1'b1;
              st_wa = c[AW-1:0];
              st_wd = in_if.data.load_value;
              c = c + 1'b1;
            end else begin
              ovf_d = 1'b1;
              obuf_d = '{sorted_value: '0, error_flag: 1'b1};
              ovalid_d = 1'b1;
            end
            cnt_d = c;
            if (in_if.data.is_last) begin
              closed_d = 1'b1;
              if (c != '0) begin
                push = 1'b1;
                push_lo = '0;
                push_hi = AW'(c - 1'b1);
                push_ph = 2'd0;
                sp_d = sp_q + 1'b1;
                state_d = ST_FRAME;
              end
            end
          end
        end
      end
      ST_RD_WAIT: begin
        st_ra = AW'(ridx_q);
        state_d = ST_RD_DONE;
      end
      ST_RD_DONE: begin
        if (32'(ridx_q) < 32'(cnt_q)) begin
          obuf_d = '{sorted_value: st_rd, error_flag: ovf_q};
        end else begin
          obuf_d = '{sorted_value: '0, error_flag: 1'b1};
        end
        ovalid_d = 1'b1;
        state_d = ST_IDLE;
      end
      ST_FRAME: begin
        lo_d = top_lo; hi_d = top_hi;
        mid_d = AW'(top_lo + (span >> 1));
        if (32'(span) <= 32'(thr_q)) begin
          state_d = ST_INS_INIT;
        end else begin
          case (top_ph)
            2'd0: begin
              setph = 1'b1; new_ph = 2'd1;
              push = 1'b1; push_lo = top_lo; push_hi = AW'(top_lo + (span >> 1));
              sp_d = sp_q + 1'b1;
            end
            2'd1: begin
              setph = 1'b1; new_ph = 2'd2;
              push = 1'b1; push_lo = AW'(top_lo + (span >> 1) + 1'b1); push_hi = top_hi;
              sp_d = sp_q + 1'b1;
            end
            default: begin
              x_d = (AW+1)'(top_lo);
              y_d = (AW+1)'(top_lo + (span >> 1) + 1'b1);
              k_d = (AW+1)'(top_lo);
              state_d = ST_MRG_RD;
            end
          endcase
        end
      end
      ST_INS_INIT: begin
        i_d = (AW+1)'(lo_q) + 1'b1;
        state_d = ST_INS_KEY_RD;
      end
      ST_INS_KEY_RD: begin
        if (i_q > (AW+1)'(hi_q)) begin
          state_d = ST_RET;
        end else begin
          st_ra = i_q[AW-1:0];
          a_d = (AW+1)'(lo_q);
          b_d = i_q;
          state_d = ST_INS_KEY_WT;
        end
      end
      ST_INS_KEY_WT: begin
        key_d = st_rd;
        state_d = ST_INS_BS_RD;
      end
      ST_INS_BS_RD: begin
        if (a_q < b_q) begin
          st_ra = mpos[AW-1:0];
          state_d = ST_INS_BS_WT;
        end else begin
          j_d = i_q;
          state_d = ST_INS_SH_RD;
        end
      end
      ST_INS_BS_WT: begin
        if (less_s(key_q, st_rd)) b_d = mpos;
        else a_d = mpos + 1'b1;
        state_d = ST_INS_BS_RD;
      end
      ST_INS_SH_RD: begin
        if (j_q > a_q) begin
          st_ra = AW'(j_q - 1'b1);
          state_d = ST_INS_SH_WT;
        end else begin
          state_d = ST_INS_PUT;
        end
      end
      ST_INS_SH_WT: begin
        st_we = 1'b1; st_wa = j_q[AW-1:0]; st_wd = st_rd;
        j_d = j_q - 1'b1;
        state_d = ST_INS_SH_RD;
      end
      ST_INS_PUT: begin
        st_we = 1'b1; st_wa = a_q[AW-1:0]; st_wd = key_q;
        i_d = i_q + 1'b1;
        state_d = ST_INS_KEY_RD;
      end
      // Merge: store port fetches x then y; at most one compare per element.
      ST_MRG_RD: begin
        if (k_q > (AW+1)'(hi_q)) begin
          k_d = (AW+1)'(lo_q);
          state_d = ST_CPY_RD;
        end else if (x_q > (AW+1)'(mid_q)) begin
          st_ra = y_q[AW-1:0];
          j_d = (AW+1)'(2);
          state_d = ST_MRG_WT;
        end else if (y_q > (AW+1)'(hi_q)) begin
          st_ra = x_q[AW-1:0];
          j_d = (AW+1)'(1);
          state_d = ST_MRG_WT;
        end else begin
          st_ra = x_q[AW-1:0];
          j_d = '0;
          state_d = ST_MRG_WT;
        end
      end
      ST_MRG_WT: begin
        if (j_q == '0) begin
          vx_d = st_rd;
          st_ra = y_q[AW-1:0];
          state_d = ST_MRG_CMP;
        end else begin
          mb_we = 1'b1; mb_wa = k_q[AW-1:0]; mb_wd = st_rd;
          k_d = k_q + 1'b1;
          if (j_q[1]) y_d = y_q + 1'b1;
          else x_d = x_q + 1'b1;
          state_d = ST_MRG_RD;
        end
      end
      ST_MRG_CMP: begin
        mb_we = 1'b1; mb_wa = k_q[AW-1:0];
        k_d = k_q + 1'b1;
        if (less_s(vx_q, st_rd)) begin
          mb_wd = vx_q; x_d = x_q + 1'b1;
        end else begin
          mb_wd = st_rd; y_d = y_q + 1'b1;
        end
        state_d = ST_MRG_RD;
      end
      ST_CPY_RD: begin
        if (k_q > (AW+1)'(hi_q)) begin
          state_d = ST_RET;
        end else begin
          mb_ra = k_q[AW-1:0];
          state_d = ST_CPY_WT;
        end
      end
      ST_CPY_WT: begin
        st_we = 1'b1; st_wa = k_q[AW-1:0]; st_wd = mb_rd;
        k_d = k_q + 1'b1;
        state_d = ST_CPY_RD;
      end
      ST_RET: begin
        sp_d = sp_q - 1'b1;
        state_d = (sp_q == 1) ? ST_IDLE : ST_FRAME;
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
